>>> src/sldf_pkg.sv
// types, constants and crc step function for the length-delimited deframer
package sldf_pkg;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACCEPT  = 3'd0,
        KIND_DROP    = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [8:0]  position;
        logic [7:0]  data_length;
        logic [7:0]  command_code;
        logic [23:0] dest_address;
        logic [23:0] source_address;
        logic        frame_end;
    } result_t;

    // register index taken from the word address bit
    localparam logic CFG_IDX_TIMEOUT = 1'b0;
    localparam logic CFG_IDX_POLY    = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] POLY_RESET    = 16'hA001;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    localparam logic [8:0] HDR_LEN  = 9'd14;
    localparam logic [8:0] CRC_LEN  = 9'd2;
    localparam logic [8:0] DST_POS  = 9'd0;
    localparam logic [8:0] SRC_POS  = 9'd5;
    localparam logic [8:0] LEN_POS  = 9'd10;
    localparam logic [8:0] CMD_POS  = 9'd13;
    localparam logic [8:0] MAX_POS  = 9'd270;
    localparam logic [7:0] SYNC_BYTE = 8'h80;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_byte(
        input logic [15:0] crc,
        input logic [7:0]  b,
        input logic [15:0] poly
    );
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/sync_length_deframer_crc16.sv
// Length-delimited serial deframer with a reflected CRC-16 check.
//
// Input channel (item_valid / item_stall / item): each item is either a
// received byte or one idle time tick. Result channel (result_valid /
// result_stall / result): at most one result per item, telling whether the
// byte was taken into a frame, dropped out of sync, completed a good or a
// bad frame, or whether a tick aborted a partial frame on timeout.
// A result is registered and shows in the cycle after its item is taken.
// Throughput: one item per cycle unless stalled; the byte-wide crc step
// and the header decode sit between input handshake and result register.
// The result register is one deep: while it holds a result and the receiver
// stalls, item_stall is high and no item is taken, ticks included.
// Reset clears the frame state and idle count and loads the register
// defaults (timeout 100 ticks, polynomial 0xA001). Registers are written
// over the APB port at byte address 0 (timeout) and 4 (polynomial); the
// user must write them only while the block is idle; it does not check.
module sync_length_deframer_crc16
    import sldf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] timeout_reg;
    logic [15:0] poly_reg;

    logic [8:0]  pos_reg,     pos_next;
    logic [7:0]  len_reg,     len_next;
    logic [23:0] dest_reg,    dest_next;
    logic [23:0] src_reg,     src_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [15:0] crc_reg,     crc_next;
    logic [7:0]  rx_crc_reg,  rx_crc_next;
    logic [15:0] idle_reg,    idle_next;

    logic        result_valid_reg, result_valid_next;
    result_t     result_reg,       result_next;

    logic        accept;
    logic        cfg_write;
    logic [8:0]  data_end;
    logic        emit;
    logic        clear;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            CFG_IDX_TIMEOUT: prdata = {16'h0000, timeout_reg};
            CFG_IDX_POLY:    prdata = {16'h0000, poly_reg};
            default:         prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            poly_reg    <= POLY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                CFG_IDX_TIMEOUT: timeout_reg <= pwdata[15:0];
                CFG_IDX_POLY:    poly_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        dest_next   = dest_reg;
        src_next    = src_reg;
        cmd_next    = cmd_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        idle_next   = idle_reg;
        result_next = result_reg;
        emit        = 1'b0;
        clear       = 1'b0;
        data_end    = HDR_LEN + {1'b0, len_reg};

        if (accept)
        begin
            if (item.operation == OP_TICK)
            begin
                if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 16'd1;
                end
                if (pos_reg != 9'd0 && idle_next >= timeout_reg)
                begin
                    emit        = 1'b1;
                    clear       = 1'b1;
                    result_next = '{KIND_TIMEOUT, 8'h00, pos_reg, len_reg, cmd_reg,
                                    dest_reg, src_reg, 1'b0};
                end
            end
            else
            begin
                idle_next = 16'd0;
                emit      = 1'b1;
                if ((pos_reg == DST_POS || pos_reg == SRC_POS) && item.rx_byte != SYNC_BYTE)
                begin
                    // out of sync: report with the held header, then restart
                    clear       = 1'b1;
                    result_next = '{KIND_DROP, item.rx_byte, pos_reg, len_reg, cmd_reg,
                                    dest_reg, src_reg, 1'b0};
                end
                else
                begin
                    if (pos_reg >= 9'd1 && pos_reg <= 9'd3)
                    begin
                        dest_next = {dest_reg[15:0], item.rx_byte};
                    end
                    else if (pos_reg >= SRC_POS + 9'd1 && pos_reg <= SRC_POS + 9'd3)
                    begin
                        src_next = {src_reg[15:0], item.rx_byte};
                    end
                    else if (pos_reg == LEN_POS)
                    begin
                        len_next = item.rx_byte;
                    end
                    else if (pos_reg == CMD_POS)
                    begin
                        cmd_next = item.rx_byte;
                    end

                    data_end    = HDR_LEN + {1'b0, len_next};
                    result_next = '{KIND_ACCEPT, item.rx_byte, pos_reg, len_next, cmd_next,
                                    dest_next, src_next, 1'b0};
                    pos_next    = pos_reg + 9'd1;

                    if (pos_reg < data_end)
                    begin
                        crc_next = crc_byte(crc_reg, item.rx_byte, poly_reg);
                    end
                    else if (pos_reg == data_end)
                    begin
                        rx_crc_next = item.rx_byte;
                    end
                    else if (pos_reg == data_end + CRC_LEN - 9'd1)
                    begin
                        // crc arrives little-endian: low byte held, high byte now
                        clear                  = 1'b1;
                        result_next.frame_end  = 1'b1;
                        result_next.kind       = ({item.rx_byte, rx_crc_reg} == crc_reg)
                                                 ? KIND_GOOD : KIND_BAD;
                    end
                end
            end
        end

        if (clear)
        begin
            pos_next    = 9'd0;
            len_next    = 8'h00;
            dest_next   = 24'h000000;
            src_next    = 24'h000000;
            cmd_next    = 8'h00;
            crc_next    = 16'h0000;
            rx_crc_next = 8'h00;
        end

        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= 9'd0;
            len_reg          <= 8'h00;
            dest_reg         <= 24'h000000;
            src_reg          <= 24'h000000;
            cmd_reg          <= 8'h00;
            crc_reg          <= 16'h0000;
            rx_crc_reg       <= 8'h00;
            idle_reg         <= 16'h0000;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg          <= pos_next;
            len_reg          <= len_next;
            dest_reg         <= dest_next;
            src_reg          <= src_next;
            cmd_reg          <= cmd_next;
            crc_reg          <= crc_next;
            rx_crc_reg       <= rx_crc_next;
            idle_reg         <= idle_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("frame position out of range");

    a_frame_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            (result_reg.frame_end == (result_reg.kind == KIND_GOOD ||
                                      result_reg.kind == KIND_BAD)))
        else $error("frame_end disagrees with result kind");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_TICK && pos_reg == 9'd0) |=>
            (pos_reg == 9'd0 && $stable(result_valid_reg)) || !$past(result_stall))
        else $error("tick outside a frame changed frame state");

    a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.kind == KIND_TIMEOUT) |->
            (result_reg.byte_value == 8'h00 && result_reg.position != 9'd0))
        else $error("timeout abort with bad fields");
`endif

endmodule

>>> tb/sv/tb_sync_length_deframer_crc16.sv
// self-checking testbench for the length-delimited deframer with crc-16 check
module tb_sync_length_deframer_crc16;
    import sldf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [2:0] ADDR_TIMEOUT = {CFG_IDX_TIMEOUT, 2'b00};
    localparam logic [2:0] ADDR_POLY    = {CFG_IDX_POLY, 2'b00};

    class frame_tracker;
        logic [15:0] timeout_ticks;
        logic [15:0] poly;
        logic [8:0]  pos;
        logic [7:0]  len_seen;
        logic [7:0]  cmd_seen;
        logic [23:0] dest_seen;
        logic [23:0] src_seen;
        logic [15:0] crc_run;
        logic [15:0] crc_rx;
        logic [15:0] idle_ticks;
        result_t     pending_results[$];
        int          fail_count;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            poly = POLY_RESET;
            idle_ticks = '0;
            fail_count = 0;
            clear_frame();
        endfunction

        // bit-serial form: feedback is crc lsb xor data bit
        static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b,
                                                logic [15:0] p);
            logic fb;
            for (int i = 0; i < 8; i++)
            begin
                fb = crc[0] ^ b[i];
                crc = crc >> 1;
                if (fb)
                begin
                    crc = crc ^ p;
                end
            end
            return crc;
        endfunction

        function void clear_frame();
            pos = '0;
            len_seen = '0;
            cmd_seen = '0;
            dest_seen = '0;
            src_seen = '0;
            crc_run = '0;
            crc_rx = '0;
        endfunction

        function void queue_result(kind_t k, logic [7:0] b, logic [8:0] at, logic fend);
            result_t r;
            r.kind = k;
            r.byte_value = b;
            r.position = at;
            r.data_length = len_seen;
            r.command_code = cmd_seen;
            r.dest_address = dest_seen;
            r.source_address = src_seen;
            r.frame_end = fend;
            pending_results = {pending_results, r};
        endfunction

        // returns 1 when the item produces a result
        function bit take_item(item_t it);
            int data_end;
            logic [7:0] b;
            b = it.rx_byte;
            if (it.operation == OP_TICK)
            begin
                if (idle_ticks != IDLE_MAX)
                begin
                    idle_ticks = idle_ticks + 16'd1;
                end
                if (pos != 0 && idle_ticks >= timeout_ticks)
                begin
                    queue_result(KIND_TIMEOUT, 8'h00, pos, 1'b0);
                    clear_frame();
                    return 1'b1;
                end
                return 1'b0;
            end
            idle_ticks = '0;
            if ((pos == DST_POS || pos == SRC_POS) && b != SYNC_BYTE)
            begin
                queue_result(KIND_DROP, b, pos, 1'b0);
                clear_frame();
                return 1'b1;
            end
            if (pos >= DST_POS + 9'd1 && pos <= DST_POS + 9'd3)
            begin
                dest_seen = {dest_seen[15:0], b};
            end
            else if (pos >= SRC_POS + 9'd1 && pos <= SRC_POS + 9'd3)
            begin
                src_seen = {src_seen[15:0], b};
            end
            else if (pos == LEN_POS)
            begin
                len_seen = b;
            end
            else if (pos == CMD_POS)
            begin
                cmd_seen = b;
            end
            data_end = int'(HDR_LEN) + int'(len_seen);
            if (int'(pos) < data_end)
            begin
                crc_run = crc16_step(crc_run, b, poly);
            end
            else if (int'(pos) == data_end)
            begin
                crc_rx = {8'h00, b};
            end
            else if (int'(pos) == data_end + int'(CRC_LEN) - 1)
            begin
                crc_rx[15:8] = b;
                queue_result((crc_rx == crc_run) ? KIND_GOOD : KIND_BAD, b, pos, 1'b1);
                clear_frame();
                return 1'b1;
            end
            queue_result(KIND_ACCEPT, b, pos, 1'b0);
            pos = pos + 9'd1;
            return 1'b1;
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: kind %0d byte 0x%0h",
                       got.kind, got.byte_value);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("position", want.position, got.position);
            compare_field("data_length", want.data_length, got.data_length);
            compare_field("command_code", want.command_code, got.command_code);
            compare_field("dest_address", want.dest_address, got.dest_address);
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_tracker tracker;
    int results_due_count;
    int quiet_cycles;
    int idle_mode;

    sync_length_deframer_crc16 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 0: no gaps, 1: full random gaps, 2: occasional gaps
    function automatic int pick_gap();
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 17);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                tracker.check_result(result);
            end
            if (item_valid && !item_stall)
            begin
                if (tracker.take_item(item))
                begin
                    results_due_count++;
                end
            end
            if ((result_valid && !result_stall) || (item_valid && !item_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    // receiver: random stall before taking each result
    initial
    begin
        int hold;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = pick_gap();
            result_stall = (hold > 0);
            repeat (hold) @(negedge clk);
            result_stall = 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
        $display("FAIL sync_length_deframer_crc16");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid = 1'b0;
            item = item_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        item_t it;
        it.operation = OP_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_tick();
        item_t it;
        it.operation = OP_TICK;
        it.rx_byte = 8'($urandom);
        send_item(it);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] timeout_val, input logic [15:0] p);
        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        apb_write(ADDR_TIMEOUT, {16'h0000, timeout_val});
        tracker.timeout_ticks = timeout_val;
        apb_write(ADDR_POLY, {16'h0000, p});
        tracker.poly = p;
    endtask

    // cut_len < 0 sends the whole frame; tick_n ticks go in before byte tick_at
    task automatic send_frame(input logic [23:0] dest, input logic [23:0] src,
                              input logic [7:0] len, input logic [7:0] cmd,
                              input logic [15:0] crc_flip, input int cut_len,
                              input int tick_at, input int tick_n);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        frame_bytes = {SYNC_BYTE, dest[23:16], dest[15:8], dest[7:0], 8'($urandom),
                       SYNC_BYTE, src[23:16], src[15:8], src[7:0], 8'($urandom),
                       len, 8'($urandom), 8'($urandom), cmd};
        repeat (len) frame_bytes = {frame_bytes, 8'($urandom)};
        crc = '0;
        foreach (frame_bytes[i])
        begin
            crc = frame_tracker::crc16_step(crc, frame_bytes[i], tracker.poly);
        end
        crc = crc ^ crc_flip;
        frame_bytes = {frame_bytes, crc[7:0], crc[15:8]};
        foreach (frame_bytes[i])
        begin
            if (cut_len >= 0 && i >= cut_len)
            begin
                break;
            end
            if (i == tick_at)
            begin
                repeat (tick_n) send_tick();
            end
            send_byte(frame_bytes[i]);
        end
    endtask

    // mostly well-formed frames with random content, some noise and broken frames
    task automatic run_random(input int results_wanted);
        int start_count;
        int choice;
        int cut;
        int tick_at;
        int tick_n;
        logic [7:0]  len;
        logic [15:0] flip;
        start_count = results_due_count;
        while (results_due_count - start_count < results_wanted)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                idle_mode = $urandom_range(0, 2);
            end
            choice = $urandom_range(0, 99);
            if (choice < 65)
            begin
                len = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
                flip = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0;
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15 + len) : -1;
                tick_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15 + len) : -1;
                if ($urandom_range(0, 3) == 0 && tracker.timeout_ticks < 16'd200)
                begin
                    tick_n = tracker.timeout_ticks;
                end
                else
                begin
                    tick_n = $urandom_range(1, 3);
                end
                send_frame(24'($urandom), 24'($urandom), len, 8'($urandom), flip,
                           cut, tick_at, tick_n);
            end
            else if (choice < 85)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_byte($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 5)) send_tick();
            end
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        results_due_count = 0;
        quiet_cycles = 0;
        idle_mode = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: out-of-sync bytes at both address blocks, idle tick,
        // good and bad frames at field extremes, timeout abort
        send_byte(8'h00);
        send_tick();
        send_byte(8'hFF);
        send_frame(24'h123456, 24'h0, 8'h00, 8'h00, 16'h0, 5, -1, 0);
        send_byte(8'h7F);
        send_frame(24'hFFFFFF, 24'h000000, 8'h00, 8'hFF, 16'h0, -1, -1, 0);
        send_frame(24'h000000, 24'hFFFFFF, 8'h01, 8'h00, 16'h8000, -1, -1, 0);
        send_frame(24'hA5A5A5, 24'h5A5A5A, 8'h02, 8'h11, 16'h0, 3, -1, 0);
        repeat (102) send_tick();

        set_config(16'd1, 16'h0000);
        run_random(90);

        // widest timeout: a few ticks leave the partial frame in place
        set_config(16'hFFFF, 16'hFFFF);
        idle_mode = 0;
        send_frame(24'hABCDEF, 24'h123456, 8'hFF, 8'h5A, 16'h0, -1, -1, 0);
        send_frame(24'h010203, 24'h040506, 8'h04, 8'h77, 16'h0, 7, -1, 0);
        repeat (4) send_tick();
        run_random(90);

        set_config(16'($urandom_range(2, 40)), 16'($urandom));
        run_random(90);

        set_config(16'd100, 16'h8408);
        run_random(90);

        while (tracker.pending_results.size() != 0) @(negedge clk);
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (tracker.fail_count == 0)
        begin
            $display("PASS sync_length_deframer_crc16");
        end
        else
        begin
            $display("FAIL sync_length_deframer_crc16");
        end
        $finish;
    end

endmodule
